// ----- hw/rtl/stq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the sorted timeout queue
// no dependencies; imported by every module of the block

package stq_pkg;

  // default sizing and limits
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);

  // reset value of the minimum delay register
  localparam logic [15:0] MIN_DELAY_RST = 16'd10;

  // input item codes
  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_SCHEDULE = 2'd1,
    MODE_CANCEL   = 2'd2
  } mode_e;

  // result item codes
  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_SHORT    = 2'd2,
    KIND_EXPIRED  = 2'd3
  } kind_e;

  // shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  // stored contents of one timeout besides its due time
  typedef struct packed {
    logic [15:0] handler;
    logic [31:0] arg_first;
    logic [31:0] arg_second;
    logic        nonblocking;
  } stq_fields_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stq_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared add / subtract unit for due times and wrapping compares
// depends on stq_pkg

module stq_alu import stq_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  alu_op_e              op_i,
  input  logic [TIME_BITS-1:0] a_i,
  input  logic [TIME_BITS-1:0] b_i,
  output logic [TIME_BITS-1:0] res_o,
  output logic                 neg_o
);

  // wrapping sum or difference over the time width
  always_comb begin
    unique case (op_i)
      ALU_ADD: res_o = a_i + b_i;
      ALU_SUB: res_o = a_i - b_i;
      default: res_o = a_i + b_i;
    endcase
  end

  // sign of a wrapping difference: set when b lies after a
  assign neg_o = res_o[TIME_BITS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/stq_slot_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// per-slot timeout store: due time and handler fields
// one write port, one registered read port; depends on stq_pkg

module stq_slot_mem import stq_pkg::*; #(
  parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter  int TIME_BITS   = TIME_BITS_DEF,
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [SLOT_W-1:0]    waddr_i,
  input  logic [TIME_BITS-1:0] wdue_i,
  input  stq_fields_t          wfields_i,
  input  logic                 re_i,
  input  logic [SLOT_W-1:0]    raddr_i,
  output logic [TIME_BITS-1:0] rdue_o,
  output stq_fields_t          rfields_o
);

  logic [TIME_BITS-1:0] due_mem    [QUEUE_DEPTH];
  stq_fields_t          fields_mem [QUEUE_DEPTH];

  // write and registered read; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      due_mem[waddr_i]    <= wdue_i;
      fields_mem[waddr_i] <= wfields_i;
    end
    if (re_i) begin
      rdue_o    <= due_mem[raddr_i];
      rfields_o <= fields_mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stq_order_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// order list: slot numbers in due order, by queue position
// one write port, one registered read port; depends on stq_pkg

module stq_order_mem import stq_pkg::*; #(
  parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] waddr_i,
  input  logic [SLOT_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [SLOT_W-1:0] raddr_i,
  output logic [SLOT_W-1:0] rdata_o
);

  logic [SLOT_W-1:0] order_mem [QUEUE_DEPTH];

  // write and registered read; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      order_mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= order_mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_timeout_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// sorted timeout queue: sequencer over the order list, the slot store and one shared adder
// schedule: scan for the lowest free slot, walk and compare entries, move later entries down, answer
// cancel: search the order list for the slot, move later entries up; no result beat
// tick: advance the clock, then per expiry check the head, emit and unlink it, then a last head check
// one item at a time, each result beat held until out_ready_i; reset clears clock, marks, count
// depends on stq_pkg, stq_alu, stq_slot_mem, stq_order_mem

module sorted_timeout_queue import stq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_min_delay_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] delay_i,
  input  logic        nonblocking_i,
  input  logic [15:0] handler_i,
  input  logic [31:0] arg_first_i,
  input  logic [31:0] arg_second_i,
  input  logic [3:0]  cancel_slot_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [15:0] out_handler_o,
  output logic [31:0] out_arg_first_o,
  output logic [31:0] out_arg_second_o,
  output logic        out_nonblocking_o,
  output logic        last_o
);

  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [17:0] {
    S_IDLE       = 18'b000000000000000001,
    S_FIND       = 18'b000000000000000010,
    S_WALK       = 18'b000000000000000100,
    S_WALK_ORD   = 18'b000000000000001000,
    S_WALK_CMP   = 18'b000000000000010000,
    S_SHIFT      = 18'b000000000000100000,
    S_SHIFT_WR   = 18'b000000000001000000,
    S_SEARCH     = 18'b000000000010000000,
    S_SEARCH_CMP = 18'b000000000100000000,
    S_DEL        = 18'b000000001000000000,
    S_DEL_WR     = 18'b000000010000000000,
    S_TICK       = 18'b000000100000000000,
    S_HEAD       = 18'b000001000000000000,
    S_HEAD_ORD   = 18'b000010000000000000,
    S_HEAD_CMP   = 18'b000100000000000000,
    S_TAKE       = 18'b001000000000000000,
    S_EMIT       = 18'b010000000000000000,
    S_OUT        = 18'b100000000000000000
  } state_e;

  // control state
  state_e                 state_q, state_d;
  logic [TIME_BITS-1:0]   now_q, now_d;
  logic [15:0]            min_delay_q;
  logic [CNT_W-1:0]       pend_q, pend_d;
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic                   tick_q, tick_d;
  logic                   have_q, have_d;
  logic [RES_CNT_W-1:0]   n_q, n_d;
  logic                   out_valid_q, out_valid_d;

  // working registers
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [SLOT_W-1:0]      scan_q, scan_d;
  logic [TIME_BITS-1:0]   due_q, due_d;
  logic [15:0]            delay_q, delay_d;
  stq_fields_t            fields_q, fields_d;
  stq_fields_t            buf_q, buf_d;
  logic [SLOT_W-1:0]      buf_slot_q, buf_slot_d;
  kind_e                  out_kind_q, out_kind_d;
  logic [3:0]             out_slot_q, out_slot_d;
  stq_fields_t            out_fields_q, out_fields_d;
  logic                   out_last_q, out_last_d;

  // memory ports
  logic                   ord_we, ord_re;
  logic [SLOT_W-1:0]      ord_waddr, ord_wdata, ord_raddr, ord_rdata;
  logic                   slot_we, slot_re;
  logic [SLOT_W-1:0]      slot_waddr, slot_raddr;
  logic [TIME_BITS-1:0]   slot_wdue, slot_rdue;
  stq_fields_t            slot_rfields;

  // shared adder
  alu_op_e                alu_op;
  logic [TIME_BITS-1:0]   alu_a, alu_b, alu_res;
  logic                   alu_neg;

  // helpers
  logic [CNT_W-1:0]       pos_p1, idx_m1;
  logic [SLOT_W-1:0]      cancel_idx;
  logic                   cancel_ok;
  logic                   tick_end;

  assign pos_p1     = pos_q + CNT_W'(1);
  assign idx_m1     = idx_q - CNT_W'(1);
  assign cancel_idx = SLOT_W'(cancel_slot_i);
  assign cancel_ok  = (int'(cancel_slot_i) < QUEUE_DEPTH) && valid_q[cancel_idx];

  // adder operands by state
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = now_q;
    alu_b  = '0;
    unique case (state_q)
      S_FIND: begin
        alu_b = TIME_BITS'(delay_q);
      end
      S_WALK_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = due_q;
        alu_b  = slot_rdue;
      end
      S_TICK: begin
        alu_b = TIME_BITS'(1);
      end
      S_HEAD_CMP: begin
        alu_op = ALU_SUB;
        alu_b  = slot_rdue;
      end
      default: ;
    endcase
  end

  stq_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .neg_o (alu_neg)
  );

  stq_slot_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .we_i      (slot_we),
    .waddr_i   (slot_waddr),
    .wdue_i    (slot_wdue),
    .wfields_i (fields_q),
    .re_i      (slot_re),
    .raddr_i   (slot_raddr),
    .rdue_o    (slot_rdue),
    .rfields_o (slot_rfields)
  );

  stq_order_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_order_mem (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    now_d        = now_q;
    pend_d       = pend_q;
    valid_d      = valid_q;
    tick_d       = tick_q;
    have_d       = have_q;
    n_d          = n_q;
    out_valid_d  = out_valid_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    scan_d       = scan_q;
    due_d        = due_q;
    delay_d      = delay_q;
    fields_d     = fields_q;
    buf_d        = buf_q;
    buf_slot_d   = buf_slot_q;
    out_kind_d   = out_kind_q;
    out_slot_d   = out_slot_q;
    out_fields_d = out_fields_q;
    out_last_d   = out_last_q;
    ord_we       = 1'b0;
    ord_waddr    = '0;
    ord_wdata    = '0;
    ord_re       = 1'b0;
    ord_raddr    = '0;
    slot_we      = 1'b0;
    slot_waddr   = '0;
    slot_wdue    = alu_res;
    slot_re      = 1'b0;
    slot_raddr   = ord_rdata;
    tick_end     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          delay_d  = delay_i;
          fields_d = '{handler: handler_i, arg_first: arg_first_i,
                       arg_second: arg_second_i, nonblocking: nonblocking_i};
          tick_d   = 1'b0;
          case (mode_e'(mode_i))
            MODE_TICK: begin
              tick_d  = 1'b1;
              state_d = S_TICK;
            end
            MODE_SCHEDULE: begin
              if (delay_i < min_delay_q) begin
                out_valid_d  = 1'b1;
                out_kind_d   = KIND_SHORT;
                out_slot_d   = '0;
                out_fields_d = '0;
                out_last_d   = 1'b1;
                state_d      = S_OUT;
              end else if (pend_q >= CNT_W'(QUEUE_DEPTH)) begin
                out_valid_d  = 1'b1;
                out_kind_d   = KIND_FULL;
                out_slot_d   = '0;
                out_fields_d = '0;
                out_last_d   = 1'b1;
                state_d      = S_OUT;
              end else begin
                scan_d  = '0;
                state_d = S_FIND;
              end
            end
            MODE_CANCEL: begin
              if (cancel_ok) begin
                slot_d  = cancel_idx;
                pos_d   = '0;
                state_d = S_SEARCH;
              end
            end
            default: ;
          endcase
        end
      end

      // lowest free slot, due time into the store
      S_FIND: begin
        if (!valid_q[scan_q]) begin
          slot_we          = 1'b1;
          slot_waddr       = scan_q;
          due_d            = alu_res;
          slot_d           = scan_q;
          valid_d[scan_q]  = 1'b1;
          pos_d            = '0;
          state_d          = S_WALK;
        end else if (scan_q == SLOT_W'(QUEUE_DEPTH - 1)) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_FULL;
          out_slot_d   = '0;
          out_fields_d = '0;
          out_last_d   = 1'b1;
          state_d      = S_OUT;
        end else begin
          scan_d = scan_q + SLOT_W'(1);
        end
      end

      // walk past entries due at or before the new one
      S_WALK: begin
        if (pos_q == pend_q) begin
          idx_d   = pend_q;
          state_d = S_SHIFT;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = pos_q[SLOT_W-1:0];
          state_d   = S_WALK_ORD;
        end
      end

      S_WALK_ORD: begin
        slot_re    = 1'b1;
        slot_raddr = ord_rdata;
        state_d    = S_WALK_CMP;
      end

      S_WALK_CMP: begin
        if (!alu_neg) begin
          pos_d   = pos_p1;
          state_d = S_WALK;
        end else begin
          idx_d   = pend_q;
          state_d = S_SHIFT;
        end
      end

      // open a gap at the insert position, tail first
      S_SHIFT: begin
        if (idx_q == pos_q) begin
          ord_we       = 1'b1;
          ord_waddr    = pos_q[SLOT_W-1:0];
          ord_wdata    = slot_q;
          pend_d       = pend_q + CNT_W'(1);
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_ACCEPTED;
          out_slot_d   = 4'(slot_q);
          out_fields_d = '0;
          out_last_d   = 1'b1;
          state_d      = S_OUT;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = idx_m1[SLOT_W-1:0];
          state_d   = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        ord_we    = 1'b1;
        ord_waddr = idx_q[SLOT_W-1:0];
        ord_wdata = ord_rdata;
        idx_d     = idx_m1;
        state_d   = S_SHIFT;
      end

      // locate the slot to cancel in the order list
      S_SEARCH: begin
        if (pos_q == pend_q) begin
          valid_d[slot_q] = 1'b0;
          state_d         = S_IDLE;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = pos_q[SLOT_W-1:0];
          state_d   = S_SEARCH_CMP;
        end
      end

      S_SEARCH_CMP: begin
        if (ord_rdata == slot_q) begin
          state_d = S_DEL;
        end else begin
          pos_d   = pos_p1;
          state_d = S_SEARCH;
        end
      end

      // close the gap at pos, shared by cancel and expiry
      S_DEL: begin
        if (pos_p1 >= pend_q) begin
          pend_d          = pend_q - CNT_W'(1);
          valid_d[slot_q] = 1'b0;
          state_d         = tick_q ? S_HEAD : S_IDLE;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = pos_p1[SLOT_W-1:0];
          state_d   = S_DEL_WR;
        end
      end

      S_DEL_WR: begin
        ord_we    = 1'b1;
        ord_waddr = pos_q[SLOT_W-1:0];
        ord_wdata = ord_rdata;
        pos_d     = pos_p1;
        state_d   = S_DEL;
      end

      // advance the clock
      S_TICK: begin
        now_d   = alu_res;
        n_d     = '0;
        have_d  = 1'b0;
        state_d = S_HEAD;
      end

      // look at the head entry
      S_HEAD: begin
        if (n_q == RES_CNT_W'(MAX_RESULTS) || pend_q == '0) begin
          tick_end = 1'b1;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = '0;
          state_d   = S_HEAD_ORD;
        end
      end

      S_HEAD_ORD: begin
        slot_d     = ord_rdata;
        slot_re    = 1'b1;
        slot_raddr = ord_rdata;
        state_d    = S_HEAD_CMP;
      end

      // head due: send the held beat first, it is not the last one
      S_HEAD_CMP: begin
        if (!alu_neg) begin
          if (have_q) begin
            out_valid_d  = 1'b1;
            out_kind_d   = KIND_EXPIRED;
            out_slot_d   = 4'(buf_slot_q);
            out_fields_d = buf_q;
            out_last_d   = 1'b0;
            state_d      = S_EMIT;
          end else begin
            state_d = S_TAKE;
          end
        end else begin
          tick_end = 1'b1;
        end
      end

      S_EMIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d     = S_TAKE;
        end
      end

      // hold the expired entry and unlink it from the head
      S_TAKE: begin
        buf_d      = slot_rfields;
        buf_slot_d = slot_q;
        have_d     = 1'b1;
        n_d        = n_q + RES_CNT_W'(1);
        pos_d      = '0;
        state_d    = S_DEL;
      end

      S_OUT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // end of a tick: the held beat, if any, is the last one
    if (tick_end) begin
      if (have_q) begin
        out_valid_d  = 1'b1;
        out_kind_d   = KIND_EXPIRED;
        out_slot_d   = 4'(buf_slot_q);
        out_fields_d = buf_q;
        out_last_d   = 1'b1;
        state_d      = S_OUT;
      end else begin
        state_d = S_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      min_delay_q <= MIN_DELAY_RST;
      pend_q      <= '0;
      valid_q     <= '0;
      tick_q      <= 1'b0;
      have_q      <= 1'b0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      pend_q      <= pend_d;
      valid_q     <= valid_d;
      tick_q      <= tick_d;
      have_q      <= have_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        min_delay_q <= cfg_min_delay_i;
      end
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    scan_q       <= scan_d;
    due_q        <= due_d;
    delay_q      <= delay_d;
    fields_q     <= fields_d;
    buf_q        <= buf_d;
    buf_slot_q   <= buf_slot_d;
    out_kind_q   <= out_kind_d;
    out_slot_q   <= out_slot_d;
    out_fields_q <= out_fields_d;
    out_last_q   <= out_last_d;
  end

  // ports
  assign cfg_ready_o       = 1'b1;
  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign kind_o            = 2'(out_kind_q);
  assign slot_o            = out_slot_q;
  assign out_handler_o     = out_fields_q.handler;
  assign out_arg_first_o   = out_fields_q.arg_first;
  assign out_arg_second_o  = out_fields_q.arg_second;
  assign out_nonblocking_o = out_fields_q.nonblocking;
  assign last_o            = out_last_q;

  // occupancy marks and count agree between items
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(valid_q) == int'(pend_q)))
    else $error("occupancy marks disagree with pending count");

  // count never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(pend_q) <= QUEUE_DEPTH)
    else $error("pending count above queue depth");

  // no new item is taken while a result beat is offered
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  // schedule answers are single beats
  a_answer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_q != KIND_EXPIRED)) |-> last_o)
    else $error("schedule answer without last marker");

  // expiry count per tick stays within the limit
  a_expiry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(n_q) <= MAX_RESULTS)
    else $error("too many expiries in one tick");

endmodule

`default_nettype wire

// ----- tb/sv/sorted_timeout_queue_checker.sv -----
`timescale 1ns / 1ps
// result checker for the sorted timeout queue: keeps its own copy of the callout list,
// predicts every result beat from the accepted input beats and compares field by field
// depends on stq_pkg

module sorted_timeout_queue_checker import stq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration channel
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_min_delay_i,
  // input channel
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  mode_i,
  input  logic [15:0] delay_i,
  input  logic        nonblocking_i,
  input  logic [15:0] handler_i,
  input  logic [31:0] arg_first_i,
  input  logic [31:0] arg_second_i,
  input  logic [3:0]  cancel_slot_i,
  // result channel
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [15:0] out_handler_i,
  input  logic [31:0] out_arg_first_i,
  input  logic [31:0] out_arg_second_i,
  input  logic        out_nonblocking_i,
  input  logic        last_i,
  // status towards the test top
  output int          errors_o,
  output int          replies_owed_o,
  output int          replies_seen_o,
  output int          expiries_seen_o
);

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    stq_fields_t fields;
    logic        last;
  } reply_t;

  // mirrored queue state
  logic [31:0] now_q;
  logic [31:0] due_q [DEPTH];
  stq_fields_t stored_q [DEPTH];
  logic [DEPTH-1:0] busy_q;
  logic [3:0]  order_q [DEPTH];
  int          count_q;
  logic [15:0] min_delay_q;

  // replies the block still owes, oldest first
  reply_t reply_q[$];

  // due is at or before the given time, by wrapping difference
  function automatic bit due_by(input logic [31:0] due, input logic [31:0] at_time);
    logic [31:0] diff;
    diff = at_time - due;
    return diff[31] == 1'b0;
  endfunction

  function automatic reply_t make_reply(input kind_e kind, input logic [3:0] slot,
                                        input stq_fields_t fields, input logic last);
    reply_t r;
    r.kind   = kind;
    r.slot   = slot;
    r.fields = fields;
    r.last   = last;
    return r;
  endfunction

  // drop the entry at a list position, closing the gap
  function automatic void unlink_at(input int pos);
    for (int i = pos; i + 1 < count_q; i++) order_q[i] = order_q[i + 1];
    count_q--;
  endfunction

  // schedule: range check, lowest free slot, insert after all entries due no later
  function automatic void mirror_schedule(input logic [15:0] delay, input stq_fields_t f);
    int slot;
    int pos;
    logic [31:0] due;
    if (delay < min_delay_q) begin
      reply_q.push_back(make_reply(KIND_SHORT, 4'd0, '0, 1'b1));
      return;
    end
    if (count_q >= DEPTH) begin
      reply_q.push_back(make_reply(KIND_FULL, 4'd0, '0, 1'b1));
      return;
    end
    slot = 0;
    while (slot < DEPTH && busy_q[slot]) slot++;
    due = now_q + 32'(delay);
    busy_q[slot]   = 1'b1;
    due_q[slot]    = due;
    stored_q[slot] = f;
    pos = 0;
    while (pos < count_q && due_by(due_q[order_q[pos]], due)) pos++;
    for (int i = count_q; i > pos; i--) order_q[i] = order_q[i - 1];
    order_q[pos] = 4'(slot);
    count_q++;
    reply_q.push_back(make_reply(KIND_ACCEPTED, 4'(slot), '0, 1'b1));
  endfunction

  // cancel: silent, and a no-op on an empty slot
  function automatic void mirror_cancel(input logic [3:0] slot);
    int pos;
    if (!busy_q[slot]) return;
    pos = 0;
    while (pos < count_q && order_q[pos] != slot) pos++;
    if (pos < count_q) unlink_at(pos);
    busy_q[slot] = 1'b0;
  endfunction

  // tick: advance the clock, then pop due head entries, at most MAX_RESULTS of them
  function automatic void mirror_tick();
    int hits[$];
    int s;
    now_q = now_q + 32'd1;
    while (hits.size() < MAX_RESULTS && count_q > 0) begin
      s = order_q[0];
      if (!due_by(due_q[s], now_q)) break;
      hits.push_back(s);
      unlink_at(0);
      busy_q[s] = 1'b0;
    end
    foreach (hits[i])
      reply_q.push_back(make_reply(KIND_EXPIRED, 4'(hits[i]), stored_q[hits[i]],
                                   i == hits.size() - 1));
  endfunction

  // follow every beat and check every result
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t exp;
    if (!rst_ni) begin
      now_q       = '0;
      busy_q      = '0;
      count_q     = 0;
      min_delay_q = MIN_DELAY_RST;
      for (int i = 0; i < DEPTH; i++) begin
        due_q[i]    = '0;
        stored_q[i] = '0;
        order_q[i]  = '0;
      end
      reply_q.delete();
      errors_o        = 0;
      replies_owed_o  = 0;
      replies_seen_o  = 0;
      expiries_seen_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) min_delay_q = cfg_min_delay_i;

      if (in_valid_i && in_ready_i) begin
        case (mode_i)
          MODE_TICK:     mirror_tick();
          MODE_SCHEDULE: mirror_schedule(delay_i, '{handler: handler_i,
                                                    arg_first: arg_first_i,
                                                    arg_second: arg_second_i,
                                                    nonblocking: nonblocking_i});
          MODE_CANCEL:   mirror_cancel(cancel_slot_i);
          default: ;  // unused code, ignored by the block
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        replies_seen_o++;
        if (kind_i == KIND_EXPIRED) expiries_seen_o++;
        if (reply_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: result beat with nothing owed: kind %0d slot %0d last %b",
                     $time, kind_i, slot_i, last_i);
        end else begin
          exp = reply_q.pop_front();
          if (kind_i !== exp.kind || slot_i !== exp.slot ||
              out_handler_i !== exp.fields.handler ||
              out_arg_first_i !== exp.fields.arg_first ||
              out_arg_second_i !== exp.fields.arg_second ||
              out_nonblocking_i !== exp.fields.nonblocking || last_i !== exp.last) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: expected kind %0d slot %0d handler %h args %h %h nb %b last %b",
                       $time, exp.kind, exp.slot, exp.fields.handler, exp.fields.arg_first,
                       exp.fields.arg_second, exp.fields.nonblocking, exp.last);
              $display("%0t:      got kind %0d slot %0d handler %h args %h %h nb %b last %b",
                       $time, kind_i, slot_i, out_handler_i, out_arg_first_i,
                       out_arg_second_i, out_nonblocking_i, last_i);
            end
          end
        end
      end
      replies_owed_o = reply_q.size();
    end
  end

endmodule

// ----- tb/sv/sorted_timeout_queue_test.sv -----
`timescale 1ns / 1ps
// test top for the sorted timeout queue: clock, reset, stimulus, handshake idling and verdict
// depends on stq_pkg, sorted_timeout_queue and sorted_timeout_queue_checker

module sorted_timeout_queue_test;
  import stq_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 300;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_min_delay;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [15:0] delay;
  logic        nonblocking;
  logic [15:0] handler;
  logic [31:0] arg_first;
  logic [31:0] arg_second;
  logic [3:0]  cancel_slot;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [3:0]  slot;
  logic [15:0] out_handler;
  logic [31:0] out_arg_first;
  logic [31:0] out_arg_second;
  logic        out_nonblocking;
  logic        last;

  int errors;
  int replies_owed;
  int replies_seen;
  int expiries_seen;
  int items_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int cur_min_delay;
  bit hold_req;
  bit hold_ack;
  int hold_left;

  sorted_timeout_queue dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_min_delay_i   (cfg_min_delay),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .mode_i            (mode),
    .delay_i           (delay),
    .nonblocking_i     (nonblocking),
    .handler_i         (handler),
    .arg_first_i       (arg_first),
    .arg_second_i      (arg_second),
    .cancel_slot_i     (cancel_slot),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .kind_o            (kind),
    .slot_o            (slot),
    .out_handler_o     (out_handler),
    .out_arg_first_o   (out_arg_first),
    .out_arg_second_o  (out_arg_second),
    .out_nonblocking_o (out_nonblocking),
    .last_o            (last)
  );

  sorted_timeout_queue_checker u_mirror (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_min_delay_i   (cfg_min_delay),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .mode_i            (mode),
    .delay_i           (delay),
    .nonblocking_i     (nonblocking),
    .handler_i         (handler),
    .arg_first_i       (arg_first),
    .arg_second_i      (arg_second),
    .cancel_slot_i     (cancel_slot),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .kind_i            (kind),
    .slot_i            (slot),
    .out_handler_i     (out_handler),
    .out_arg_first_i   (out_arg_first),
    .out_arg_second_i  (out_arg_second),
    .out_nonblocking_i (out_nonblocking),
    .last_i            (last),
    .errors_o          (errors),
    .replies_owed_o    (replies_owed),
    .replies_seen_o    (replies_seen),
    .expiries_seen_o   (expiries_seen)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result side: random stalls, or a long hold-off counted here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one input beat, with random idle cycles ahead of it
  task automatic offer(input logic [1:0] m, input logic [15:0] d, input logic nb,
                       input logic [15:0] h, input logic [31:0] a1, input logic [31:0] a2,
                       input logic [3:0] cs);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    mode        = m;
    delay       = d;
    nonblocking = nb;
    handler     = h;
    arg_first   = a1;
    arg_second  = a2;
    cancel_slot = cs;
    in_valid    = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // random beat: mostly near-term schedules and ticks so entries actually expire
  task automatic offer_random();
    int pick;
    int sub;
    int d;
    logic [1:0] m;
    logic [3:0] cs;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    d    = $urandom_range(65535);
    cs   = 4'($urandom_range(15));
    if (pick < 42) begin
      m = MODE_TICK;
    end else if (pick < 80) begin
      m = MODE_SCHEDULE;
      if (sub < 74) begin
        d = cur_min_delay + $urandom_range(20);
        if (d > 65535) d = 65535;
      end else if (sub < 86) begin
        d = (cur_min_delay > 0) ? $urandom_range(cur_min_delay - 1)
                                : $urandom_range(3);
      end else if (sub < 94) begin
        d = $urandom_range(65535);
      end else begin
        d = 65535;
      end
    end else if (pick < 96) begin
      m = MODE_CANCEL;
      if (sub < 75) cs = 4'($urandom_range(7));
    end else begin
      m = MODE_UNUSED;
    end
    offer(m, 16'(d), 1'($urandom_range(1)), 16'($urandom_range(65535)),
          $urandom(), $urandom(), cs);
  endtask

  // let every owed result drain, then give a silent item time to finish
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_min_delay(input logic [15:0] v);
    @(negedge clk);
    cfg_valid     = 1'b1;
    cfg_min_delay = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid     = 1'b0;
    cur_min_delay = v;
  endtask

  // run limit
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int phase_send[4];
    int phase_recv[4];
    int phase_min[4];
    phase_send = '{0, 77, 0, 10};
    phase_recv = '{0, 0, 77, 10};
    phase_min  = '{3, 0, 7, 1};

    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_min_delay  = '0;
    in_valid       = 1'b0;
    mode           = MODE_TICK;
    delay          = '0;
    nonblocking    = 1'b0;
    handler        = '0;
    arg_first      = '0;
    arg_second     = '0;
    cancel_slot    = '0;
    out_ready      = 1'b0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cur_min_delay  = MIN_DELAY_RST;
    hold_req       = 1'b0;
    hold_ack       = 1'b0;
    hold_left      = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty tick, short delays, unused code, empty cancel, far entry cancelled
    offer(MODE_TICK, 16'd0, 1'b0, 16'd0, 32'd0, 32'd0, 4'd0);
    offer(MODE_SCHEDULE, 16'd9, 1'b1, 16'h1234, 32'h1, 32'h2, 4'd0);
    offer(MODE_SCHEDULE, 16'd0, 1'b0, 16'd0, 32'd0, 32'd0, 4'd0);
    offer(MODE_UNUSED, 16'hffff, 1'b1, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
    offer(MODE_CANCEL, 16'd0, 1'b0, 16'd0, 32'd0, 32'd0, 4'd15);
    offer(MODE_SCHEDULE, 16'hffff, 1'b0, 16'd0, 32'd0, 32'd0, 4'd0);
    offer(MODE_CANCEL, 16'd0, 1'b0, 16'd0, 32'd0, 32'd0, 4'd0);

    // directed: zero minimum, fill every slot due now, overflow, then one tick empties all
    settle();
    write_min_delay(16'd0);
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
      offer(MODE_SCHEDULE, 16'd0, (i == 0) ? 1'b1 : 1'($urandom_range(1)),
            (i == 0) ? 16'hffff : 16'($urandom_range(65535)),
            (i == 0) ? 32'hffff_ffff : $urandom(),
            (i == 0) ? 32'hffff_ffff : $urandom(), 4'd0);
    offer(MODE_SCHEDULE, 16'd5, 1'b0, 16'd0, 32'd0, 32'd0, 4'd0);
    offer(MODE_TICK, 16'd0, 1'b0, 16'd0, 32'd0, 32'd0, 4'd0);

    // random phases, each with its own minimum and idling pattern
    for (int p = 0; p < 4; p++) begin
      settle();
      @(posedge clk);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      write_min_delay(16'(phase_min[p]));
      if (p == 0) begin
        // long hold-off on the result side while schedules keep coming
        @(posedge clk);
        hold_req = ~hold_req;
        repeat (24)
          offer(MODE_SCHEDULE, 16'(cur_min_delay + $urandom_range(20)),
                1'($urandom_range(1)), 16'($urandom_range(65535)), $urandom(),
                $urandom(), 4'd0);
      end
      repeat (19) offer_random();
    end

    // largest minimum: nearly everything is refused or lands far out
    settle();
    write_min_delay(16'hffff);
    repeat (8) offer_random();

    // back to the reset value, sweep out whatever is left, a few more random beats
    settle();
    write_min_delay(MIN_DELAY_RST);
    for (int s = 0; s < 16; s++)
      offer(MODE_CANCEL, 16'($urandom_range(65535)), 1'($urandom_range(1)),
            16'($urandom_range(65535)), $urandom(), $urandom(), 4'(s));
    repeat (10) offer_random();

    settle();
    $display("covered %0d input beats and %0d result beats (%0d expiries)",
             items_sent, replies_seen, expiries_seen);
    $display("minimum delay swept from 0 to 65535 under four idling patterns and a long stall");
    if (errors == 0 && replies_owed == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/stq_pkg.sv
hw/rtl/stq_alu.sv
hw/rtl/stq_slot_mem.sv
hw/rtl/stq_order_mem.sv
hw/rtl/sorted_timeout_queue.sv
tb/sv/sorted_timeout_queue_checker.sv
tb/sv/sorted_timeout_queue_test.sv
